@@ rtl/core/ccc_pkg.sv @@
// Shared types and constants of the causal 3x3 convolution block.
// Used by the kernel cells and the top level; no dependencies.
`default_nettype none

package ccc_pkg;

  localparam int PIX_W          = 8;
  localparam int COEF_W         = 8;
  localparam int PROD_W         = 17;
  localparam int SUM_W          = 21;
  localparam int KSIZE          = 3;
  localparam int FW_W           = 11;
  localparam int FH_W           = 13;
  localparam int ROW_W          = 12;
  localparam int CROW_W         = 24;
  localparam int MAX_HEIGHT     = 4096;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int APB_AW         = 5;
  localparam int APB_DW         = 32;
  localparam int FRAC_BITS      = 4;

  localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = FW_W'(1024);
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = FH_W'(1024);

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_ROW0    = 3'd2,
    REG_COEF_ROW1    = 3'd3,
    REG_COEF_ROW2    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic active;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/ccc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
`default_nettype none

module ccc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ccc_cell.sv @@
// One kernel cell: a window tap register and a registered coefficient product.
// Depends on ccc_pkg for widths and the cell control struct.
`default_nettype none

module ccc_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  ccc_pkg::cell_ctrl_t                 ctrl,
  input  logic [ccc_pkg::PIX_W-1:0]           pix_in,
  input  logic signed [ccc_pkg::COEF_W-1:0]   coef,
  output logic [ccc_pkg::PIX_W-1:0]           tap,
  output logic signed [ccc_pkg::PROD_W-1:0]   prod
);
  import ccc_pkg::*;

  logic signed [PIX_W:0]    pix_s;
  logic signed [PROD_W-1:0] mult;

  assign pix_s = signed'({1'b0, pix_in});
  assign mult  = PROD_W'(coef) * PROD_W'(pix_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (ctrl.shift) begin
      tap <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      prod <= ctrl.active ? mult : '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/causal_3x3_convolution_clamp.sv @@
// Causal 3x3 convolution with clamping: top level, counters, line stores, adder, output.
// Depends on ccc_pkg, ccc_ram and ccc_cell.
//
// Usage: pixels enter in raster order on pix_valid/pix_stall with pixel_in; one
// result per pixel leaves on res_valid/res_stall with pixel_out and frame_last.
// A transfer happens on a rising edge with valid high and stall low.
// The APB port sets frame size and the three kernel rows; write it only while idle.
// Throughput is one pixel per cycle unless the line store clear, or a receiver stall
// that has backed up through every stage, holds the flow. A result is registered
// through three stages: line store read, products in the 3x3 cell array, and the
// adder tree with clamp into the output register. After reset the block clears both
// line stores, one entry per cycle; pix_stall stays high during that pass.
// When the receiver stalls, the result holds in the output register and the internal
// stages keep filling; input stalls only once every stage is occupied.
`default_nettype none

module causal_3x3_convolution_clamp #(
  parameter int MAX_WIDTH = ccc_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ccc_pkg::APB_AW-1:0]  paddr,
  input  logic [ccc_pkg::APB_DW-1:0]  pwdata,
  output logic [ccc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  logic [ccc_pkg::PIX_W-1:0]   pixel_in,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [ccc_pkg::PIX_W-1:0]   pixel_out,
  output logic                        frame_last
);
  import ccc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (FW_W > AW + 1) ? FW_W : AW + 1;

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [CROW_W-1:0] coef_row [KSIZE];

  logic            cfg_wr;
  logic [2:0]      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      coef_row[0]  <= '0;
      coef_row[1]  <= '0;
      coef_row[2]  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        REG_COEF_ROW0:    coef_row[0]  <= pwdata[CROW_W-1:0];
        REG_COEF_ROW1:    coef_row[1]  <= pwdata[CROW_W-1:0];
        REG_COEF_ROW2:    coef_row[2]  <= pwdata[CROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height);
      REG_COEF_ROW0:    prdata = APB_DW'(coef_row[0]);
      REG_COEF_ROW1:    prdata = APB_DW'(coef_row[1]);
      REG_COEF_ROW2:    prdata = APB_DW'(coef_row[2]);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size.
  logic [CW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(frame_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = FH_W'(1);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // Pipeline control.
  logic v1, v2;
  logic out_load, s2_free, s2_move, s1_free, s1_move, accept;
  logic clearing;
  logic [AW-1:0] clr_addr;

  assign out_load  = !res_valid || !res_stall;
  assign s2_free   = !v2 || out_load;
  assign s2_move   = v2 && out_load;
  assign s1_free   = !v1 || s2_free;
  assign s1_move   = v1 && s2_free;
  assign pix_stall = clearing || !s1_free;
  assign accept    = pix_valid && !pix_stall;

  // Position counters.
  logic [AW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic             last_col, last_row;

  assign last_col = (CW'(col_count) + CW'(1)) >= w_eff;
  assign last_row = (FH_W'(row_count) + FH_W'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + AW'(1);
      end
    end
  end

  // Stage 1 registers and line store access.
  logic [PIX_W-1:0] pix1, fwd_p, fwd_p2;
  logic [AW-1:0]    col1;
  logic             fwd_hit, last1, last2;
  logic             row_ge1, row_ge2, col_ge1, col_ge2;
  logic [PIX_W-1:0] prev_rdata, prev2_rdata;
  logic [PIX_W-1:0] above [KSIZE];
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PIX_W-1:0] prev_wdata, prev2_wdata;

  assign above[0] = pix1;
  assign above[1] = fwd_hit ? fwd_p  : prev_rdata;
  assign above[2] = fwd_hit ? fwd_p2 : prev2_rdata;

  assign ram_we      = clearing || s1_move;
  assign ram_waddr   = clearing ? clr_addr : col1;
  assign prev_wdata  = clearing ? '0 : pix1;
  assign prev2_wdata = clearing ? '0 : above[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
    end else begin
      v1        <= accept || (v1 && !s2_free);
      v2        <= s1_move || (v2 && !out_load);
      res_valid <= s2_move || (res_valid && res_stall);
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1    <= pixel_in;
      col1    <= col_count;
      last1   <= last_col && last_row;
      row_ge1 <= row_count != '0;
      row_ge2 <= row_count[ROW_W-1:1] != '0;
      col_ge1 <= col_count != '0;
      col_ge2 <= col_count[AW-1:1] != '0;
      fwd_hit <= s1_move && (col1 == col_count);
      fwd_p   <= pix1;
      fwd_p2  <= above[1];
    end
    if (s1_move) begin
      last2 <= last1;
    end
  end

  ccc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (prev_wdata),
    .re    (accept),
    .raddr (col_count),
    .rdata (prev_rdata)
  );

  ccc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev2 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (prev2_wdata),
    .re    (accept),
    .raddr (col_count),
    .rdata (prev2_rdata)
  );

  // 3x3 array of cells; each row shifts its taps to the right.
  logic [KSIZE-1:0]         row_ok, col_ok;
  logic [PIX_W-1:0]         cell_in  [KSIZE][KSIZE];
  logic [PIX_W-1:0]         cell_tap [KSIZE][KSIZE];
  logic signed [PROD_W-1:0] prod     [KSIZE][KSIZE];

  assign row_ok = {row_ge2, row_ge1, 1'b1};
  assign col_ok = {col_ge2, col_ge1, 1'b1};

  for (genvar i = 0; i < KSIZE; i++) begin : g_row
    for (genvar j = 0; j < KSIZE; j++) begin : g_col
      cell_ctrl_t ctrl;

      if (j == 0) begin : g_head
        assign cell_in[i][j] = above[i];
      end else begin : g_link
        assign cell_in[i][j] = cell_tap[i][j-1];
      end

      assign ctrl.shift  = s1_move;
      assign ctrl.active = row_ok[i] && col_ok[j];

      ccc_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (ctrl),
        .pix_in (cell_in[i][j]),
        .coef   (signed'(coef_row[i][COEF_W*j +: COEF_W])),
        .tap    (cell_tap[i][j]),
        .prod   (prod[i][j])
      );
    end
  end

  // Stage 2: sum of products, truncation and clamp.
  logic signed [SUM_W-1:0]    sum;
  logic [SUM_W-FRAC_BITS-1:0] quot;
  logic [PIX_W-1:0]           clamped;

  always_comb begin
    sum = '0;
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE; j++) begin
        sum = sum + SUM_W'(prod[i][j]);
      end
    end
  end

  assign quot = sum[SUM_W-1:FRAC_BITS];

  always_comb begin
    if (sum <= 0) begin
      clamped = '0;
    end else if (quot > (SUM_W-FRAC_BITS)'(255)) begin
      clamped = '1;
    end else begin
      clamped = quot[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      pixel_out  <= clamped;
      frame_last <= last2;
    end
  end

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept && !v1 && !v2)
    else $error("pixel transfer or pipeline activity during line store clear");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !s2_free |=> v1 && $stable(col1) && $stable(pix1))
    else $error("stage 1 lost or changed its pixel while blocked");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> v2)
    else $error("pixel leaving stage 1 did not reach stage 2");

  a_res_from_s2: assert property (@(posedge clk) disable iff (rst)
    !$past(res_valid) && res_valid |-> $past(v2))
    else $error("result appeared without a stage 2 pixel");

endmodule

`default_nettype wire
